// File: design/eqpx_pkg.sv
package eqpx_pkg;

  // channel and register geometry
  localparam int MAX_INPUTS = 256;
  localparam int CH_W       = $clog2(MAX_INPUTS);
  localparam int CNT_W      = CH_W + 1;
  localparam int TICK_W     = 16;
  localparam int FRAC_W     = 10;
  localparam int FRAC_ONE   = 1 << FRAC_W;
  localparam int DIV_CNT_W  = $clog2(FRAC_W + 1);

  // gain table and datapath widths
  localparam int GAIN_TABLE_DEPTH = 1024;
  localparam int GIDX_W           = $clog2(GAIN_TABLE_DEPTH);
  localparam int GAIN_W           = 16;
  localparam int GAIN_FRAC        = GAIN_W - 1;
  localparam int SAMPLE_BITS      = 24;
  localparam int PROD_W           = SAMPLE_BITS + GAIN_W;
  localparam int TERM_W           = PROD_W - GAIN_FRAC;
  localparam int ACC_W            = SAMPLE_BITS + 10;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = TICK_W;

  typedef longint unsigned u64_t;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t GAIN_MAX    = 64'd32767;
  localparam u64_t GAIN_ROUND  = 64'd16384;
  localparam u64_t TaylorDiv [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WRITE,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_COUNT = 1'b0,
    REG_FADE_TICKS  = 1'b1
  } cfg_reg_e;

  // one entry of the per-channel state memory
  typedef struct packed {
    logic [TICK_W-1:0] ramp;
    logic [FRAC_W-1:0] frac;
  } chan_state_t;

  localparam int MEM_W = $bits(chan_state_t);

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] num;
    logic [TICK_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic gain_load;
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

  typedef logic [GAIN_W-1:0] gain_rom_t [GAIN_TABLE_DEPTH];

  // quarter-sine gain, Q1.15, from a Q30 Taylor series
  function automatic logic [GAIN_W-1:0] gain_at(input int unsigned idx);
    u64_t theta;
    u64_t mag;
    u64_t sum;
    u64_t g;
    theta = (u64_t'(idx) * HALF_PI_Q30) / GAIN_TABLE_DEPTH;
    mag   = theta;
    sum   = theta;
    for (int k = 0; k < 6; k++) begin
      mag = (mag * theta) >> 30;
      mag = (mag * theta) >> 30;
      mag = mag / TaylorDiv[k];
      if (k[0] == 1'b0) begin
        sum = sum - mag;
      end else begin
        sum = sum + mag;
      end
    end
    g = (sum + GAIN_ROUND) >> 15;
    if (g > GAIN_MAX) begin
      g = GAIN_MAX;
    end
    return GAIN_W'(g);
  endfunction

  function automatic gain_rom_t build_gain_rom();
    gain_rom_t rom;
    for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
      rom[i] = gain_at(i);
    end
    return rom;
  endfunction

endpackage

// File: design/eqpx_if.sv
interface eqpx_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic [eqpx_pkg::CH_W-1:0]               channel_index;
  logic signed [eqpx_pkg::SAMPLE_BITS-1:0] sample_value;
  logic                                    frame_end;
  logic [eqpx_pkg::CNT_W-1:0]              choice_value;

  modport source (
    output valid, mode, channel_index, sample_value, frame_end, choice_value,
    input  ready
  );
  modport sink (
    input  valid, mode, channel_index, sample_value, frame_end, choice_value,
    output ready
  );
endinterface

interface eqpx_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [eqpx_pkg::SAMPLE_BITS-1:0] mix_sample;

  modport source (output valid, mix_sample, input ready);
  modport sink (input valid, mix_sample, output ready);
endinterface

interface eqpx_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [eqpx_pkg::CFG_IDX_W-1:0]    index;
  logic [eqpx_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/eqpx_ram.sv
module eqpx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/eqpx_div.sv
module eqpx_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eqpx_pkg::div_req_t req_i,
  output eqpx_pkg::div_rsp_t rsp_o
);

  // restoring division, one quotient bit a cycle; num < den is assumed
  logic [eqpx_pkg::TICK_W-1:0]    rem_q, rem_d;
  logic [eqpx_pkg::TICK_W-1:0]    den_q, den_d;
  logic [eqpx_pkg::FRAC_W-1:0]    quot_q, quot_d;
  logic [eqpx_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [eqpx_pkg::TICK_W:0]      shifted;
  logic [eqpx_pkg::TICK_W:0]      diff;
  logic                           ge;

  always_comb begin
    shifted = {rem_q, 1'b0};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quot_d = '0;
      cnt_d  = eqpx_pkg::DIV_CNT_W'(eqpx_pkg::FRAC_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[eqpx_pkg::TICK_W-1:0] : shifted[eqpx_pkg::TICK_W-1:0];
      quot_d = {quot_q[eqpx_pkg::FRAC_W-2:0], ge};
      cnt_d  = cnt_q - eqpx_pkg::DIV_CNT_W'(1);
      if (cnt_q == eqpx_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: design/eqpx_mac.sv
module eqpx_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  eqpx_pkg::mac_ctrl_t                     ctrl_i,
  input  logic [eqpx_pkg::FRAC_W-1:0]             frac_i,
  input  logic signed [eqpx_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [eqpx_pkg::ACC_W-1:0]       acc_o
);

  localparam eqpx_pkg::gain_rom_t GainRom = eqpx_pkg::build_gain_rom();
  localparam int IW_W = eqpx_pkg::FRAC_W + eqpx_pkg::GIDX_W;
  localparam int SUM_W = eqpx_pkg::ACC_W + 1;
  localparam logic signed [eqpx_pkg::ACC_W-1:0] AccMax =
    {1'b0, {(eqpx_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [eqpx_pkg::ACC_W-1:0] AccMin =
    {1'b1, {(eqpx_pkg::ACC_W-1){1'b0}}};

  logic [IW_W-1:0]                          gidx_wide;
  logic [eqpx_pkg::GIDX_W-1:0]              gidx;
  logic [eqpx_pkg::GAIN_W-1:0]              gain_q;
  logic signed [eqpx_pkg::PROD_W-1:0]       prod_q;
  logic signed [eqpx_pkg::PROD_W-1:0]       prod_shr;
  logic signed [eqpx_pkg::TERM_W-1:0]       term;
  logic signed [SUM_W-1:0]                  sum;
  logic signed [eqpx_pkg::ACC_W-1:0]        acc_q, acc_d;

  // fraction in 1/1024 steps scaled to a table index
  assign gidx_wide = IW_W'(frac_i) * IW_W'(eqpx_pkg::GAIN_TABLE_DEPTH);
  assign gidx      = gidx_wide[IW_W-1:eqpx_pkg::FRAC_W];

  // floor shift of the Q1.23 x Q1.15 product back to Q1.23
  assign prod_shr = prod_q >>> eqpx_pkg::GAIN_FRAC;
  assign term     = prod_shr[eqpx_pkg::TERM_W-1:0];
  assign sum      = {{(SUM_W-eqpx_pkg::TERM_W){term[eqpx_pkg::TERM_W-1]}}, term} +
                    {acc_q[eqpx_pkg::ACC_W-1], acc_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
        acc_d = sum[SUM_W-1] ? AccMin : AccMax;
      end else begin
        acc_d = sum[eqpx_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.gain_load) begin
      gain_q <= GainRom[gidx];
    end
    if (ctrl_i.mul_en) begin
      prod_q <= sample_i * $signed(gain_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// File: design/equal_power_crossfade_selector_top.sv
// Equal-power crossfade selector. A choice request (mode 1) picks input k-1, or silence for 0,
// clamped to input_count; it turns the chosen channel on and the previous one off, so at most
// one channel fades in while the others fade out. Sample requests (mode 0) come one channel
// at a time; each steps that channel's ramp counter and fade fraction, scales the sample by a
// quarter-sine gain and adds it to a saturating 34-bit mix; the request with frame_end set
// returns the mix saturated to 24 bits and clears it. Per-channel state lives in one 256-entry
// synchronous RAM (read, modify, write back); entries never written since reset read as zero
// through a row of valid flags, so there is no clearing pass. One request is worked on at a
// time. A sample for a channel in use is read, stepped, written back and, for a nonzero fade
// fraction, multiplied and added to the mix; when its fade fraction needs the counter divided
// by fade_ticks, the bit-serial divider yields one quotient bit a cycle, then a done flag. A frame
// end also waits while an earlier mix result sits untaken in the output register.
// Configuration is written through cfg_i: index 0 is input_count, index 1 is fade_ticks.
module equal_power_crossfade_selector_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  eqpx_in_if.sink    in_i,
  eqpx_out_if.source mix_o,
  eqpx_cfg_if.sink   cfg_i
);

  localparam logic signed [eqpx_pkg::SAMPLE_BITS-1:0] MixMax =
    {1'b0, {(eqpx_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [eqpx_pkg::SAMPLE_BITS-1:0] MixMin =
    {1'b1, {(eqpx_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam int HI_W = eqpx_pkg::ACC_W - eqpx_pkg::SAMPLE_BITS + 1;

  eqpx_pkg::state_e state_q, state_d;

  // configuration
  logic [eqpx_pkg::CNT_W-1:0]  input_count_q;
  logic [eqpx_pkg::TICK_W-1:0] fade_ticks_q;

  // selection: only the channel current_choice-1 is ever active
  logic [eqpx_pkg::CNT_W-1:0]  cur_q, cur_d;

  // request held while it is worked on
  logic [eqpx_pkg::CH_W-1:0]               chan_q, chan_d;
  logic signed [eqpx_pkg::SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                                    frame_end_q, frame_end_d;
  logic [eqpx_pkg::TICK_W-1:0]             ramp_q, ramp_d;
  logic [eqpx_pkg::FRAC_W-1:0]             frac_q, frac_d;

  // entries written since reset
  logic [eqpx_pkg::MAX_INPUTS-1:0] written_q, written_d;

  // output register
  logic                                    out_valid_q, out_valid_d;
  logic signed [eqpx_pkg::SAMPLE_BITS-1:0] out_data_q, out_data_d;

  // memory port
  logic                       mem_re, mem_we;
  eqpx_pkg::chan_state_t      mem_rdata, mem_wdata, rd_entry;

  eqpx_pkg::div_req_t                 div_req;
  eqpx_pkg::div_rsp_t                 div_rsp;
  eqpx_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [eqpx_pkg::ACC_W-1:0]  acc;

  logic [eqpx_pkg::CNT_W-1:0]  used_inputs;
  logic [eqpx_pkg::TICK_W-1:0] ticks;
  logic [eqpx_pkg::CNT_W-1:0]  choice_clamped;
  logic [eqpx_pkg::CNT_W-1:0]  active_idx;
  logic                        in_acc;
  logic                        is_active;
  logic                        step_up;
  logic                        step_down;
  logic [eqpx_pkg::TICK_W-1:0] n;
  logic [eqpx_pkg::FRAC_W-1:0] frac_old;
  logic [HI_W-1:0]             acc_hi;
  logic signed [eqpx_pkg::SAMPLE_BITS-1:0] mix_sat;
  logic                        out_free;

  // out-of-range registers act as the nearest legal value
  always_comb begin
    if (input_count_q == '0) begin
      used_inputs = eqpx_pkg::CNT_W'(1);
    end else if (input_count_q > eqpx_pkg::CNT_W'(eqpx_pkg::MAX_INPUTS)) begin
      used_inputs = eqpx_pkg::CNT_W'(eqpx_pkg::MAX_INPUTS);
    end else begin
      used_inputs = input_count_q;
    end
  end

  assign ticks = (fade_ticks_q == '0) ? eqpx_pkg::TICK_W'(1) : fade_ticks_q;
  assign choice_clamped = (in_i.choice_value > used_inputs) ? used_inputs : in_i.choice_value;

  assign in_i.ready  = (state_q == eqpx_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // entry not written since reset reads as all zero
  assign rd_entry = written_q[chan_q] ? mem_rdata : '0;
  assign n        = rd_entry.ramp;
  assign frac_old = (n == '0) ? '0 : rd_entry.frac;

  assign active_idx = cur_q - eqpx_pkg::CNT_W'(1);
  assign is_active  = (cur_q != '0) && ({1'b0, chan_q} == active_idx);
  assign step_up    = is_active && (n < ticks);
  assign step_down  = !is_active && (n != '0);

  // mix saturated to the sample width
  assign acc_hi  = acc[eqpx_pkg::ACC_W-1:eqpx_pkg::SAMPLE_BITS-1];
  assign mix_sat = ((&acc_hi) || !(|acc_hi)) ? acc[eqpx_pkg::SAMPLE_BITS-1:0] :
                   (acc[eqpx_pkg::ACC_W-1] ? MixMin : MixMax);
  assign out_free = !out_valid_q || mix_o.ready;

  assign mem_wdata.ramp = ramp_q;
  assign mem_wdata.frac = frac_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    chan_d      = chan_q;
    sample_d    = sample_q;
    frame_end_d = frame_end_q;
    ramp_d      = ramp_q;
    frac_d      = frac_q;
    written_d   = written_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    div_req     = '0;
    mac_ctrl    = '0;

    if (out_valid_q && mix_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      eqpx_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.mode) begin
            // a repeated choice leaves everything as it is
            cur_d = choice_clamped;
          end else begin
            chan_d      = in_i.channel_index;
            sample_d    = in_i.sample_value;
            frame_end_d = in_i.frame_end;
            if ({1'b0, in_i.channel_index} < used_inputs) begin
              mem_re  = 1'b1;
              state_d = eqpx_pkg::ST_READ;
            end else begin
              // channel not in use: only frame_end matters
              state_d = eqpx_pkg::ST_FIN;
            end
          end
        end
      end

      eqpx_pkg::ST_READ: begin
        if (step_up) begin
          ramp_d = n + eqpx_pkg::TICK_W'(1);
        end else if (step_down) begin
          ramp_d = n - eqpx_pkg::TICK_W'(1);
        end else begin
          ramp_d = n;
        end
        frac_d  = frac_old;
        state_d = eqpx_pkg::ST_WRITE;
        if ((step_up && n != '0) || step_down) begin
          if (n >= ticks) begin
            // counter at or above fade_ticks: fraction saturates
            frac_d = '1;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = n;
            div_req.den   = ticks;
            state_d       = eqpx_pkg::ST_DIV;
          end
        end
      end

      eqpx_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          frac_d  = div_rsp.quot;
          state_d = eqpx_pkg::ST_WRITE;
        end
      end

      eqpx_pkg::ST_WRITE: begin
        mem_we             = 1'b1;
        written_d[chan_q]  = 1'b1;
        mac_ctrl.gain_load = 1'b1;
        state_d = (frac_q != '0) ? eqpx_pkg::ST_MUL : eqpx_pkg::ST_FIN;
      end

      eqpx_pkg::ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = eqpx_pkg::ST_ACC;
      end

      eqpx_pkg::ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = eqpx_pkg::ST_FIN;
      end

      eqpx_pkg::ST_FIN: begin
        if (!frame_end_q) begin
          state_d = eqpx_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d      = 1'b1;
          out_data_d       = mix_sat;
          mac_ctrl.acc_clr = 1'b1;
          state_d          = eqpx_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = eqpx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= eqpx_pkg::ST_IDLE;
      cur_q         <= '0;
      written_q     <= '0;
      out_valid_q   <= 1'b0;
      input_count_q <= eqpx_pkg::CNT_W'(1);
      fade_ticks_q  <= eqpx_pkg::TICK_W'(44);
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          eqpx_pkg::REG_INPUT_COUNT: input_count_q <= cfg_i.data[eqpx_pkg::CNT_W-1:0];
          eqpx_pkg::REG_FADE_TICKS:  fade_ticks_q  <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q      <= chan_d;
    sample_q    <= sample_d;
    frame_end_q <= frame_end_d;
    ramp_q      <= ramp_d;
    frac_q      <= frac_d;
    out_data_q  <= out_data_d;
  end

  assign mix_o.valid      = out_valid_q;
  assign mix_o.mix_sample = out_data_q;

  // per-channel ramp counter and fade fraction
  eqpx_ram #(
    .WIDTH (eqpx_pkg::MEM_W),
    .DEPTH (eqpx_pkg::MAX_INPUTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (chan_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (in_i.channel_index),
    .rdata_o (mem_rdata)
  );

  // fade fraction = counter * 1024 / fade_ticks
  eqpx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // gain lookup, multiply and mix accumulation
  eqpx_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .frac_i   (frac_q),
    .sample_i (sample_q),
    .acc_o    (acc)
  );

endmodule

// File: design/eqpx_chk.sv
module eqpx_chk (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    in_mode,
  input logic                                    in_frame_end,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [eqpx_pkg::SAMPLE_BITS-1:0] out_mix
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_mix))
    else $error("mix result dropped or changed while stalled");

  // a choice request never makes a result
  a_choice_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode && !out_valid |=> !out_valid)
    else $error("result after a choice request");

  // a sample without frame end makes no result
  a_no_frame_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_mode && !in_frame_end && !out_valid |=> !out_valid)
    else $error("result without frame end");

  // a sample request, once taken, makes the block busy and drops in_ready
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_mode |=> !in_ready)
    else $error("sample request not worked on");

endmodule

bind equal_power_crossfade_selector_top eqpx_chk u_eqpx_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_mode      (in_i.mode),
  .in_frame_end (in_i.frame_end),
  .out_valid    (mix_o.valid),
  .out_ready    (mix_o.ready),
  .out_mix      (mix_o.mix_sample)
);
